// ===== design/hamming_packet_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Hamming packet receiver assertion macros
// Shared concurrent-assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef HAMMING_PACKET_RECEIVER_DEFINES_SVH
`define HAMMING_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define HPR_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");
// next-cycle implication, checked outside reset
`define HPR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");
`else
`define HPR_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define HPR_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== design/hpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Hamming packet receiver package
// Field widths, transfer types, pipeline stage types and the power-of-ten table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

    localparam int CW_W                 = 16;
    localparam int CODE_BITS            = 12;
    localparam int BYTE_W               = 8;
    localparam int SYN_W                = 4;
    localparam int IDX_W                = 40;
    localparam int INDEX_DIGITS_DEFAULT = 12;

    // code positions of the data bits, MSB first
    localparam int DATA_POS [BYTE_W] = '{3, 5, 6, 7, 9, 10, 11, 12};

    typedef struct packed {
        logic [CW_W-1:0] codeword;
        logic            last_of_packet;
    } in_item_t;

    typedef struct packed {
        logic              data_valid;
        logic [BYTE_W-1:0] data_byte;
        logic [SYN_W-1:0]  syndrome;
        logic              packet_end;
        logic [IDX_W-1:0]  packet_index;
        logic [IDX_W-1:0]  lost_count;
        logic              transfer_done;
    } out_item_t;

    // after decode
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [SYN_W-1:0]  syndrome;
        logic              last;
    } dec_item_t;

    // after index accumulation
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [SYN_W-1:0]  syndrome;
        logic              last;
        logic              payload;
        logic [IDX_W-1:0]  index;
    } idx_item_t;

    // transfer strobes into the loss tracker
    typedef struct packed {
        logic take_gap;
        logic take_out;
    } loss_ctl_t;

    function automatic logic [IDX_W-1:0] pow10(input logic [3:0] k);
        logic [IDX_W-1:0] r;
        case (k)
            4'd0:    r = 40'd1;
            4'd1:    r = 40'd10;
            4'd2:    r = 40'd100;
            4'd3:    r = 40'd1000;
            4'd4:    r = 40'd10000;
            4'd5:    r = 40'd100000;
            4'd6:    r = 40'd1000000;
            4'd7:    r = 40'd10000000;
            4'd8:    r = 40'd100000000;
            4'd9:    r = 40'd1000000000;
            4'd10:   r = 40'd10000000000;
            4'd11:   r = 40'd100000000000;
            4'd12:   r = 40'd1000000000000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/hpr_decoder.sv =====
// ----------------------------------------------------------------------------
// Hamming(12,8) decoder
// Syndrome, single-bit correction and data-bit extraction for one codeword.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpr_decoder
    import hpr_pkg::*;
(
    input  logic [CW_W-1:0]   codeword,
    output logic [SYN_W-1:0]  syndrome,
    output logic [BYTE_W-1:0] data_byte
);

    logic [CW_W-1:0] flip;
    logic [CW_W-1:0] fixed;

    always_comb
    begin
        syndrome = '0;
        for (int p = 1; p <= CODE_BITS; p++)
        begin
            if (codeword[CW_W-p])
                syndrome = syndrome ^ SYN_W'(p);
        end
    end

    // no match for syndromes above the code length: leave the word alone
    always_comb
    begin
        flip = '0;
        for (int p = 1; p <= CODE_BITS; p++)
        begin
            if (syndrome == SYN_W'(p))
                flip[CW_W-p] = 1'b1;
        end
        fixed = codeword ^ flip;
    end

    always_comb
    begin
        for (int i = 0; i < BYTE_W; i++)
            data_byte[BYTE_W-1-i] = fixed[CW_W-DATA_POS[i]];
    end

endmodule

`default_nettype wire

// ===== design/hpr_index_unit.sv =====
// ----------------------------------------------------------------------------
// Packet index accumulator
// Folds header digits into the index, each pre-scaled by its place weight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpr_index_unit
    import hpr_pkg::*;
#(
    parameter int INDEX_DIGITS = INDEX_DIGITS_DEFAULT
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  dec_item_t dec_in,
    output idx_item_t idx_out
);

    localparam int PW = $clog2(INDEX_DIGITS + 1);

    // scaled_reg holds the digits so far times 10 per digit still missing
    logic [PW-1:0]           pos_reg;
    logic [IDX_W-1:0]        scaled_reg;
    logic                    payload;
    logic [PW-1:0]           rem_m1;
    logic [IDX_W-1:0]        weight;
    logic [BYTE_W+IDX_W-1:0] prod;
    logic [IDX_W-1:0]        sum;
    logic [IDX_W-1:0]        index_now;

    always_comb
    begin
        payload   = (pos_reg == PW'(INDEX_DIGITS));
        rem_m1    = PW'(INDEX_DIGITS - 1) - pos_reg;
        weight    = pow10(4'(rem_m1));
        prod      = (BYTE_W+IDX_W)'(dec_in.data_byte) * (BYTE_W+IDX_W)'(weight);
        sum       = scaled_reg + prod[IDX_W-1:0];
        index_now = payload ? scaled_reg : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            scaled_reg <= '0;
        end
        else if (take)
        begin
            if (dec_in.last)
            begin
                pos_reg    <= '0;
                scaled_reg <= '0;
            end
            else if (!payload)
            begin
                pos_reg    <= pos_reg + 1'b1;
                scaled_reg <= sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            idx_out.data_byte <= dec_in.data_byte;
            idx_out.syndrome  <= dec_in.syndrome;
            idx_out.last      <= dec_in.last;
            idx_out.payload   <= payload;
            idx_out.index     <= dec_in.last ? index_now : '0;
        end
    end

endmodule

`default_nettype wire

// ===== design/hpr_loss_unit.sv =====
// ----------------------------------------------------------------------------
// Lost-packet tracker
// Expected-index tracking, gap measurement, saturating loss count and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hpr_loss_unit
    import hpr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  loss_ctl_t        ctl,
    input  logic [IDX_W-1:0] total_packets,
    input  idx_item_t        idx_in,
    output out_item_t        out_item
);

    typedef struct packed {
        idx_item_t        item;
        logic             done;
        logic [IDX_W-1:0] gap;
    } gap_item_t;

    // next_exp_reg is the last accounted index plus one
    logic [IDX_W-1:0] next_exp_reg;
    logic [IDX_W-1:0] lost_reg;
    gap_item_t        gap_reg;
    logic             ahead;
    logic [IDX_W-1:0] exp_next;
    logic [IDX_W:0]   lost_sum;
    logic [IDX_W-1:0] lost_next;

    always_comb
    begin
        ahead    = idx_in.index > next_exp_reg;
        exp_next = (ahead ? idx_in.index : next_exp_reg) + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            next_exp_reg <= IDX_W'(1);
        else if (ctl.take_gap && idx_in.last)
            next_exp_reg <= exp_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_gap)
        begin
            gap_reg.item <= idx_in;
            gap_reg.done <= idx_in.last && (idx_in.index == total_packets);
            gap_reg.gap  <= (idx_in.last && ahead) ? idx_in.index - next_exp_reg : '0;
        end
    end

    // saturate at all ones
    always_comb
    begin
        lost_sum  = {1'b0, lost_reg} + {1'b0, gap_reg.gap};
        lost_next = lost_sum[IDX_W] ? '1 : lost_sum[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lost_reg <= '0;
        else if (ctl.take_out)
            lost_reg <= lost_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take_out)
        begin
            out_item.data_valid    <= gap_reg.item.payload;
            out_item.data_byte     <= gap_reg.item.data_byte;
            out_item.syndrome      <= gap_reg.item.syndrome;
            out_item.packet_end    <= gap_reg.item.last;
            out_item.packet_index  <= gap_reg.item.index;
            out_item.lost_count    <= lost_next;
            out_item.transfer_done <= gap_reg.done;
        end
    end

endmodule

`default_nettype wire

// ===== design/hamming_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// Hamming packet receiver
// Decodes a stream of Hamming(12,8) codewords into header index and payload.
// ----------------------------------------------------------------------------
// One codeword is taken per clock unless a waiting result backs up the
// pipe to the input, and one result comes out for each, in order. The
// pipeline is five registers deep: input register, decoded byte,
// accumulated index, index gap, result register. Every stage advances
// on its own when the one ahead is empty or moving, so a waiting result
// stalls only as far back as the pipe is full. The per-cycle figure is
// set by the two state loops: the index accumulator (a byte times a power
// of ten added into a 40-bit word) and the expected-index compare. The
// user must write total_packets through cfg_we/cfg_wdata while the block
// is idle, which it does not enforce; no clearing pass, ready out of reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hamming_packet_receiver_defines.svh"

module hamming_packet_receiver
    import hpr_pkg::*;
#(
    parameter int INDEX_DIGITS = INDEX_DIGITS_DEFAULT
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_wdata
);

    // stage occupancy
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic out_valid_reg;

    // stage advance: a stage loads when it is empty or its item moves on
    logic en1;
    logic en2;
    logic en3;
    logic en4;
    logic en5;

    in_item_t         s1_data_reg;
    dec_item_t        s2_data_reg;
    idx_item_t        s3_data;
    logic [SYN_W-1:0] dec_syndrome;
    logic [BYTE_W-1:0] dec_byte;
    logic [IDX_W-1:0] total_packets_reg;
    loss_ctl_t        loss_ctl;

    assign en5 = !out_valid_reg || out_ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign in_ready  = en1;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg  <= in_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) s4_valid_reg  <= s3_valid_reg;
            if (en5) out_valid_reg <= s4_valid_reg;
        end
    end

    // hold the configured packet total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            total_packets_reg <= '0;
        else if (cfg_we)
            total_packets_reg <= cfg_wdata;
    end

    // capture the incoming transfer
    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
            s1_data_reg <= in_data;
    end

    hpr_decoder u_decoder (
        .codeword  (s1_data_reg.codeword),
        .syndrome  (dec_syndrome),
        .data_byte (dec_byte)
    );

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_data_reg.data_byte <= dec_byte;
            s2_data_reg.syndrome  <= dec_syndrome;
            s2_data_reg.last      <= s1_data_reg.last_of_packet;
        end
    end

    // index state updates only when a decoded item actually moves forward
    hpr_index_unit #(
        .INDEX_DIGITS (INDEX_DIGITS)
    ) u_index (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (en3 && s2_valid_reg),
        .dec_in  (s2_data_reg),
        .idx_out (s3_data)
    );

    assign loss_ctl.take_gap = en4 && s3_valid_reg;
    assign loss_ctl.take_out = en5 && s4_valid_reg;

    hpr_loss_unit u_loss (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (loss_ctl),
        .total_packets (total_packets_reg),
        .idx_in        (s3_data),
        .out_item      (out_data)
    );

    // input backpressure only when every stage holds an item
    `HPR_ASSERT_IMPLY(a_ready_full, clk, rst_n, !in_ready, s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && out_valid_reg)
    // index and done appear only on a packet-end result
    `HPR_ASSERT_IMPLY(a_end_fields, clk, rst_n, out_valid && !out_data.packet_end, out_data.packet_index == '0 && !out_data.transfer_done)
    // loss count never goes backwards between results
    `HPR_ASSERT_NEXT(a_lost_mono, clk, rst_n, out_valid && out_ready, !out_valid || out_data.lost_count >= $past(out_data.lost_count))

endmodule

`default_nettype wire
